### hdl/b85enc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the base-85 text encoder
// no dependencies

package b85enc_pkg;

   localparam int WORDS_PER_LINE = 28;
   localparam int WCNT_W = $clog2(WORDS_PER_LINE + 1);

   localparam logic [6:0] DIGIT_OFFSET   = 7'd35;
   localparam logic [6:0] BACKSLASH_CODE = 7'd92;
   localparam logic [6:0] QMARK_CODE     = 7'd63;

   // floor(w / 85) == (w * RECIP_85) >> RECIP_SHIFT for every 32-bit w
   localparam logic [31:0] RECIP_85    = 32'hC0C0C0C1;
   localparam int          RECIP_SHIFT = 38;

   localparam logic [2:0] LAST_DIGIT = 3'd4;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [31:0] word;
      logic        line_end;
      logic        last;
   } word_entry_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       line_end;
      logic       last_char;
      logic       stream_done;
   } char_result_type;

endpackage

### hdl/b85enc_front.sv
`timescale 1ns / 1ps
// front end: gathers bytes into little-endian words and counts words per line
// depends on b85enc_pkg

module b85enc_front
   import b85enc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   output logic           full,
   input  logic [7:0]     req_data_byte,
   input  logic           req_stream_end,
   output logic           q_push,
   output word_entry_type q_entry,
   input  logic           q_full
);

   logic [23:0]       acc_ff, acc_in;
   logic [1:0]        pos_ff, pos_in;
   logic [WCNT_W-1:0] wcnt_ff, wcnt_in;
   logic              accept;
   logic              line_end;
   logic [31:0]       byte_shifted;

   assign full   = q_full;
   assign accept = push && !q_full;

   always_comb begin
      byte_shifted = {24'd0, req_data_byte} << {pos_ff, 3'b000};
      line_end     = (wcnt_ff >= WCNT_W'(WORDS_PER_LINE - 1));
      q_entry.word     = {8'd0, acc_ff} | byte_shifted;
      q_entry.line_end = line_end;
      q_entry.last     = req_stream_end;
      q_push = accept && (pos_ff == 2'd3 || req_stream_end);

      acc_in  = acc_ff;
      pos_in  = pos_ff;
      wcnt_in = wcnt_ff;
      if (accept) begin
         if (q_push) begin
            acc_in = 24'd0;
            pos_in = 2'd0;
            if (req_stream_end || line_end) begin
               wcnt_in = '0;
            end else begin
               wcnt_in = wcnt_ff + WCNT_W'(1);
            end
         end else begin
            acc_in = acc_ff | byte_shifted[23:0];
            pos_in = pos_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pos_ff  <= '0;
         wcnt_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         pos_ff  <= pos_in;
         wcnt_ff <= wcnt_in;
      end
   end

endmodule

### hdl/b85enc_queue.sv
`timescale 1ns / 1ps
// short word queue between the front end and the digit emitter
// depends on b85enc_pkg

module b85enc_queue
   import b85enc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_en,
   input  word_entry_type wr_entry,
   output logic           q_full,
   input  logic           rd_en,
   output word_entry_type rd_entry,
   output logic           rd_valid
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   word_entry_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]           count_ff, count_in;
   logic                     do_wr, do_rd;

   assign q_full   = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_entry = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !q_full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

### hdl/b85enc_back.sv
`timescale 1ns / 1ps
// back end: splits words into base-85 digits, one character per cycle while pop
// keeps up, adds escape backslashes, holds result register; depends on b85enc_pkg

module b85enc_back
   import b85enc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            escape_enable,
   input  logic            q_valid,
   input  word_entry_type  q_entry,
   output logic            q_pop,
   output logic            empty,
   input  logic            pop,
   output char_result_type rsp
);

   logic            busy_ff, busy_in;
   logic [31:0]     word_ff, word_in;
   logic [2:0]      cnt_ff, cnt_in;
   logic            esc_ff, esc_in;
   logic            le_ff, le_in;
   logic            last_ff, last_in;
   logic [6:0]      prev_ff, prev_in;
   logic            out_valid_ff, out_valid_in;
   char_result_type out_ff, out_in;

   logic [63:0] prod;
   logic [31:0] quot;
   logic [6:0]  q85_low;
   logic [6:0]  rem;
   logic [6:0]  raw_char;
   logic [6:0]  dig_char;
   logic        adv;
   logic        esc_emit;
   logic        final_digit;
   logic        finish;

   always_comb begin
      prod     = 64'(word_ff) * 64'(RECIP_85);
      quot     = 32'(prod >> RECIP_SHIFT);
      // remainder is below 85, so seven low bits of w - 85q are enough
      q85_low  = (quot[6:0] << 6) + (quot[6:0] << 4) + (quot[6:0] << 2) + quot[6:0];
      rem      = word_ff[6:0] - q85_low;
      raw_char = rem + DIGIT_OFFSET;
      dig_char = (raw_char >= BACKSLASH_CODE) ? raw_char + 7'd1 : raw_char;
   end

   assign adv         = !out_valid_ff || pop;
   assign esc_emit    = busy_ff && escape_enable && !esc_ff
                        && dig_char == QMARK_CODE && prev_ff == QMARK_CODE;
   assign final_digit = (cnt_ff == LAST_DIGIT);
   assign finish      = busy_ff && adv && !esc_emit && final_digit;
   assign q_pop       = q_valid && (!busy_ff || finish);
   assign empty       = !out_valid_ff;
   assign rsp         = out_ff;

   always_comb begin
      busy_in      = busy_ff;
      word_in      = word_ff;
      cnt_in       = cnt_ff;
      esc_in       = esc_ff;
      le_in        = le_ff;
      last_in      = last_ff;
      prev_in      = prev_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;

      if (adv) begin
         out_valid_in = busy_ff;
         if (busy_ff) begin
            if (esc_emit) begin
               out_in.out_char    = BACKSLASH_CODE;
               out_in.line_end    = 1'b0;
               out_in.last_char   = 1'b0;
               out_in.stream_done = 1'b0;
               esc_in             = 1'b1;
            end else begin
               out_in.out_char    = dig_char;
               out_in.line_end    = final_digit && le_ff;
               out_in.last_char   = final_digit;
               out_in.stream_done = final_digit && last_ff;
               esc_in             = 1'b0;
               word_in            = quot;
               cnt_in             = cnt_ff + 3'd1;
               // end of stream returns the character history to zero
               prev_in            = (final_digit && last_ff) ? 7'd0 : dig_char;
               if (final_digit) begin
                  busy_in = 1'b0;
               end
            end
         end
      end

      if (q_pop) begin
         busy_in = 1'b1;
         word_in = q_entry.word;
         cnt_in  = 3'd0;
         esc_in  = 1'b0;
         le_in   = q_entry.line_end;
         last_in = q_entry.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         esc_ff       <= 1'b0;
         prev_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         esc_ff       <= esc_in;
         prev_ff      <= prev_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      le_ff   <= le_in;
      last_ff <= last_in;
      out_ff  <= out_in;
   end

endmodule

### hdl/base85_text_encoder_top.sv
`timescale 1ns / 1ps
// base-85 text encoder: bytes in through a push/full port, characters out
// through an empty/pop port, one escape control register.
// Usage:
//   push a byte with req_data_byte / req_stream_end while full is low. Every
//   fourth byte, or a byte flagged as stream end, closes a little-endian word
//   (zero padded) that yields five digit characters, low base-85 digit first.
//   Characters wait on the rsp_ ports while empty is low; pop takes one.
//   csr_escape_enable is written through csr_valid / csr_ready (ready is always
//   high); write it only while no work is in flight.
// Path: a closed word enters the word queue, then, with the emitter free,
//   the emitter's word register, and its first character the result register.
// Throughput: one character per cycle while pop keeps up, from a single digit
//   unit (one 32x32 reciprocal multiply per digit); escape backslashes take a
//   character slot too. A two-entry word queue lets bytes keep coming while
//   a word is being emitted.
// Reset: clears queue, counters and character history; escape is enabled.
// Stall: while pop stays low the held character stays put, the emitter stops,
//   the queue fills and full rises.

module base85_text_encoder_top
   import b85enc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_data_byte,
   input  logic       req_stream_end,
   output logic       empty,
   input  logic       pop,
   output logic [6:0] rsp_out_char,
   output logic       rsp_line_end,
   output logic       rsp_last_char,
   output logic       rsp_stream_done,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_escape_enable
);

   logic            esc_en_ff, esc_en_in;
   logic            q_push, q_full, q_pop, q_valid;
   word_entry_type  wr_entry, rd_entry;
   char_result_type rsp;

   assign csr_ready = 1'b1;
   assign esc_en_in = (csr_valid && csr_ready) ? csr_escape_enable : esc_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_en_ff <= 1'b1;
      end else begin
         esc_en_ff <= esc_en_in;
      end
   end

   b85enc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_data_byte  (req_data_byte),
      .req_stream_end (req_stream_end),
      .q_push         (q_push),
      .q_entry        (wr_entry),
      .q_full         (q_full)
   );

   b85enc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_entry (wr_entry),
      .q_full   (q_full),
      .rd_en    (q_pop),
      .rd_entry (rd_entry),
      .rd_valid (q_valid)
   );

   b85enc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .escape_enable (esc_en_ff),
      .q_valid       (q_valid),
      .q_entry       (rd_entry),
      .q_pop         (q_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp           (rsp)
   );

   assign rsp_out_char    = rsp.out_char;
   assign rsp_line_end    = rsp.line_end;
   assign rsp_last_char   = rsp.last_char;
   assign rsp_stream_done = rsp.stream_done;

endmodule
